### src/sli_pkg.sv
package sli_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [2:0] t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_DELETED  = 3'd1;
    localparam t_status ST_NOTFOUND = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic  ins;
        logic  del;
        t_word value;
    } t_cmd;

endpackage

### src/sli_cell.sv
module sli_cell (
    input  logic          i_clk,
    input  sli_pkg::t_cmd i_cmd,
    input  logic          i_occ,
    input  logic          i_left_lt,
    input  sli_pkg::t_word i_left_val,
    input  sli_pkg::t_word i_right_val,
    output logic          o_lt,
    output logic          o_match,
    output sli_pkg::t_word o_val,
    output sli_pkg::t_word o_nxt
);
    import sli_pkg::*;

    t_word r_val;
    t_word n_val;

    // Occupied cells form a sorted prefix, so o_lt is a prefix of the row too.
    assign o_lt    = i_occ && (r_val < i_cmd.value);
    assign o_match = i_occ && i_left_lt && !o_lt && (r_val == i_cmd.value);

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins && !o_lt) begin
            n_val = i_left_lt ? i_cmd.value : i_left_val;
        end else if (i_cmd.del && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_nxt = n_val;

endmodule

### src/sorted_list_insert_delete.sv
// Sorted list with insert and delete.
// Input channel: i_valid / o_stall carry one word of i_mode and i_value.
//   Mode insert places the value at its ascending place (duplicates kept);
//   mode delete removes one stored copy of the value.
// Output channel: o_valid / i_stall carry one word per input word with
//   o_status, o_count (values held, low five bits) and o_smallest
//   (smallest held value, zero when the list is empty).
// Result: registered, and it shows up in the cycle after the input is accepted.
// Throughput: one word per cycle while o_stall is low; every cell compares
//   against the broadcast value in the same cycle, and the cells from the operation's place on shift by one place.
// Stall: the result register holds while i_stall is high, and o_stall
//   goes high only while a held result is still waiting.
// Reset: the list empties and the output valid flag clears; cell contents
//   are not cleared, a fill counter marks which cells are in use.
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  sli_pkg::t_word       i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sli_pkg::t_status     o_status,
    output logic [4:0]           o_count,
    output sli_pkg::t_word       o_smallest
);
    import sli_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_o_valid;
    t_status       r_status;
    t_status       n_status;
    logic [4:0]    r_count;
    t_word         r_smallest;

    logic          acc;
    logic          full;
    logic          empty;
    logic          found;
    t_cmd          cmd;

    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] match;
    t_word               val [CAPACITY];
    t_word               nxt [CAPACITY];

    // Hold the input off only while a finished result waits for the receiver.
    assign o_stall = r_o_valid && i_stall;
    assign acc     = i_valid && !o_stall;

    assign full  = (r_fill == FW'(CAPACITY));
    assign empty = (r_fill == '0);
    assign found = |match;

    // Broadcast the operation; drop it when it leaves the list unchanged.
    always_comb begin
        cmd.value = i_value;
        cmd.ins   = acc && (i_mode == MODE_INSERT) && !full;
        cmd.del   = acc && (i_mode == MODE_DELETE) && found;
    end

    // Row of cells; each hands its value and its compare flag to neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_lt;
        t_word  left_val;
        t_word  right_val;

        if (g == 0) begin : g_head
            assign left_lt  = 1'b1;
            assign left_val = i_value;
        end else begin : g_body
            assign left_lt  = lt[g-1];
            assign left_val = val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = i_value;
        end else begin : g_inner
            assign right_val = val[g+1];
        end

        sli_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_occ       (FW'(g) < r_fill),
            .i_left_lt   (left_lt),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_lt        (lt[g]),
            .o_match     (match[g]),
            .o_val       (val[g]),
            .o_nxt       (nxt[g])
        );
    end

    // Status and new fill count of the accepted word.
    always_comb begin
        n_fill = r_fill;
        if (cmd.ins) begin
            n_fill = r_fill + FW'(1);
        end else if (cmd.del) begin
            n_fill = r_fill - FW'(1);
        end

        case (i_mode)
            MODE_INSERT: n_status = full ? ST_FULL : ST_INSERTED;
            MODE_DELETE: n_status = empty ? ST_EMPTY : (found ? ST_DELETED : ST_NOTFOUND);
            default:     n_status = ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_fill <= n_fill;
            end
            if (acc) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload; advance only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status   <= n_status;
            r_count    <= 5'(n_fill);
            r_smallest <= (n_fill == '0) ? '0 : nxt[0];
        end
    end

    assign o_valid    = r_o_valid;
    assign o_status   = r_status;
    assign o_count    = r_count;
    assign o_smallest = r_smallest;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |=> r_fill == $past(r_fill) + FW'(1))
        else $error("insert did not grow the list");

    a_delete_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del |=> r_fill == $past(r_fill) - FW'(1))
        else $error("delete did not shrink the list");

    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("more than one delete position");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_mode == MODE_DELETE) && empty |=> r_status == ST_EMPTY)
        else $error("delete on empty list not reported");
`endif

endmodule
